>>> hdl/btm_pkg.sv
`default_nettype none

package btm_pkg;

   typedef enum logic [1:0] {
      ACT_BEAT_ON  = 2'd0,
      ACT_BEAT_OFF = 2'd1,
      ACT_STOP     = 2'd2,
      ACT_RESET    = 2'd3
   } action_type;

   typedef struct packed {
      action_type  action;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic        display_write;
      logic [7:0]  digit0_segments;
      logic [7:0]  digit1_segments;
      logic [7:0]  digit2_segments;
      logic [7:0]  digit3_segments;
      logic [15:0] tempo_bpm;
   } rsp_type;

   typedef struct packed {
      logic        display_write;
      logic [7:0]  digit0_segments;
      logic [7:0]  digit1_segments;
      logic [7:0]  digit2_segments;
      logic [7:0]  digit3_segments;
      logic        do_div;
      logic [31:0] interval;
   } cmd_type;

   typedef enum logic [0:0] {
      BK_IDLE = 1'b0,
      BK_DIV  = 1'b1
   } back_state_type;

   localparam logic [7:0]  DOT_PATTERN   = 8'h80;
   localparam logic [7:0]  DASH_PATTERN  = 8'h40;
   localparam int          NUM_WIDTH     = 18;
   localparam logic [NUM_WIDTH-1:0] TEMPO_NUMERATOR = 18'd240000;
   localparam logic [15:0] TEMPO_MAX     = 16'hFFFF;
   localparam int          STEP_WIDTH    = 5;

endpackage

`default_nettype wire

>>> hdl/btm_cmd_fifo.sv
`default_nettype none

module btm_cmd_fifo
   import btm_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  wire     push,
   input  cmd_type push_data,
   output logic    full,
   input  wire     pop,
   output cmd_type pop_data,
   output logic    empty
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_push;
   logic       do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> hdl/btm_front.sv
`default_nettype none

module btm_front
   import btm_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  wire     req_push,
   input  req_type req_data,
   output logic    req_full,
   output logic    cmd_push,
   output cmd_type cmd_data,
   input  wire     cmd_full
);

   logic        beat_lit_ff;
   logic        beat_lit_in;
   logic [1:0]  position_ff;
   logic [1:0]  position_in;
   logic [31:0] start_ff;
   logic [31:0] start_in;
   logic        accept;

   assign req_full = cmd_full;
   assign accept   = req_push && !cmd_full;
   assign cmd_push = accept;

   always_comb begin
      beat_lit_in = beat_lit_ff;
      position_in = position_ff;
      start_in    = start_ff;
      cmd_data    = '0;
      cmd_data.interval = req_data.now_ms - start_ff;
      unique case (req_data.action)
         ACT_BEAT_ON: begin
            if (!beat_lit_ff) begin
               cmd_data.display_write = 1'b1;
               unique case (position_ff)
                  2'd0: cmd_data.digit0_segments = DOT_PATTERN;
                  2'd1: cmd_data.digit1_segments = DOT_PATTERN;
                  2'd2: cmd_data.digit2_segments = DOT_PATTERN;
                  default: cmd_data.digit3_segments = DOT_PATTERN;
               endcase
               if (position_ff == 2'd0) begin
                  cmd_data.do_div = (start_ff != 32'd0);
                  start_in = req_data.now_ms;
               end
               position_in = position_ff + 2'd1;
               beat_lit_in = 1'b1;
            end
         end
         ACT_BEAT_OFF: begin
            if (beat_lit_ff) begin
               cmd_data.display_write = 1'b1;
               beat_lit_in = 1'b0;
            end
         end
         ACT_STOP: begin
            cmd_data.display_write   = 1'b1;
            cmd_data.digit3_segments = DASH_PATTERN;
            beat_lit_in = 1'b0;
            position_in = 2'd0;
         end
         default: begin
            position_in = 2'd0;
            start_in    = 32'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_lit_ff <= 1'b0;
         position_ff <= 2'd0;
         start_ff    <= 32'd0;
      end else if (accept) begin
         beat_lit_ff <= beat_lit_in;
         position_ff <= position_in;
         start_ff    <= start_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/btm_back.sv
`default_nettype none

module btm_back
   import btm_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  cmd_type cmd_data,
   input  wire     cmd_empty,
   output logic    cmd_pop,
   output rsp_type rsp_data,
   output logic    rsp_empty,
   input  wire     rsp_pop
);

   back_state_type         state_ff;
   back_state_type         state_in;
   cmd_type                cmd_ff;
   cmd_type                cmd_in;
   logic [31:0]            rem_ff;
   logic [31:0]            rem_in;
   logic [NUM_WIDTH-1:0]   quo_ff;
   logic [NUM_WIDTH-1:0]   quo_in;
   logic [STEP_WIDTH-1:0]  count_ff;
   logic [STEP_WIDTH-1:0]  count_in;
   logic [15:0]            tempo_ff;
   logic [15:0]            tempo_in;
   rsp_type                rsp_ff;
   rsp_type                rsp_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;

   logic                   slot_free;
   logic                   start;
   logic                   last_step;
   logic [32:0]            rem_shift;
   logic                   fits;
   logic [32:0]            rem_sub;
   logic [31:0]            rem_step;
   logic [NUM_WIDTH-1:0]   quo_step;
   logic [15:0]            tempo_calc;

   function automatic rsp_type build_rsp(input cmd_type cmd, input logic [15:0] tempo);
      rsp_type r;
      r.display_write   = cmd.display_write;
      r.digit0_segments = cmd.digit0_segments;
      r.digit1_segments = cmd.digit1_segments;
      r.digit2_segments = cmd.digit2_segments;
      r.digit3_segments = cmd.digit3_segments;
      r.tempo_bpm       = tempo;
      return r;
   endfunction

   assign rsp_data  = rsp_ff;
   assign rsp_empty = !rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || rsp_pop;
   assign start     = !cmd_empty && slot_free;
   assign last_step = (count_ff == STEP_WIDTH'(NUM_WIDTH - 1));

   // One restoring division step per cycle, numerator bits enter from the top.
   assign rem_shift = {rem_ff, quo_ff[NUM_WIDTH-1]};
   assign rem_sub   = rem_shift - {1'b0, cmd_ff.interval};
   assign fits      = (rem_shift >= {1'b0, cmd_ff.interval});
   assign rem_step  = fits ? rem_sub[31:0] : rem_shift[31:0];
   assign quo_step  = {quo_ff[NUM_WIDTH-2:0], fits};

   always_comb begin
      if ((cmd_ff.interval == 32'd0) || (quo_step[NUM_WIDTH-1:16] != '0)) begin
         tempo_calc = TEMPO_MAX;
      end else begin
         tempo_calc = quo_step[15:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (start && cmd_data.do_div) begin
               state_in = BK_DIV;
            end
         end
         BK_DIV: begin
            if (last_step) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      cmd_pop      = 1'b0;
      cmd_in       = cmd_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      count_in     = count_ff;
      tempo_in     = tempo_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      unique case (state_ff)
         BK_IDLE: begin
            if (start) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd_data;
               if (cmd_data.do_div) begin
                  rem_in   = 32'd0;
                  quo_in   = TEMPO_NUMERATOR;
                  count_in = '0;
               end else begin
                  rsp_in       = build_rsp(cmd_data, tempo_ff);
                  rsp_valid_in = 1'b1;
               end
            end
         end
         BK_DIV: begin
            rem_in   = rem_step;
            quo_in   = quo_step;
            count_in = count_ff + STEP_WIDTH'(1);
            if (last_step) begin
               tempo_in     = tempo_calc;
               rsp_in       = build_rsp(cmd_ff, tempo_calc);
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         tempo_ff     <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tempo_ff     <= tempo_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      count_ff <= count_in;
      rsp_ff   <= rsp_in;
   end

endmodule

`default_nettype wire

>>> hdl/beat_indicator_tempo_meter_core.sv
`default_nettype none

// Beat indicator and tempo meter. Each beat on req_data carries an event kind and a
// millisecond timestamp, and produces exactly one beat on rsp_data holding the
// display patterns to write and the held tempo. The front end decodes events and
// tracks the lit flag, digit position and measure start, then queues a command in
// a two-entry queue. The back end retires a command straight into its response
// register, except for a beat on the first digit with a measure start held, which
// runs a restoring divider of 240000 by the interval at one quotient bit per cycle.

module beat_indicator_tempo_meter_core
   import btm_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  wire     req_push,
   input  req_type req_data,
   output logic    req_full,
   output rsp_type rsp_data,
   output logic    rsp_empty,
   input  wire     rsp_pop
);

   cmd_type push_cmd;
   cmd_type pop_cmd;
   logic    cmd_push;
   logic    cmd_full;
   logic    cmd_pop;
   logic    cmd_empty;

   btm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .cmd_push (cmd_push),
      .cmd_data (push_cmd),
      .cmd_full (cmd_full)
   );

   btm_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (push_cmd),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (pop_cmd),
      .empty     (cmd_empty)
   );

   btm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_data  (pop_cmd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

endmodule

`default_nettype wire

>>> dv/tb_top.sv
module tb_top;
   import btm_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   req_type req_data = '0;
   logic    req_full;
   rsp_type rsp_data;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;

   beat_indicator_tempo_meter_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #6000000;
      $display("Verification failed");
      $finish;
   end

   logic        shown_lit = 1'b0;
   logic [1:0]  next_digit = 2'd0;
   logic [31:0] measure_start = 32'd0;
   logic [15:0] held_tempo = 16'd0;

   rsp_type pending_displays[$];
   int      failures = 0;
   int      events_sent = 0;
   int      results_checked = 0;
   int      input_stalls = 0;
   int      drain_hold_cycles = 0;
   bit      sender_steady = 1'b0;
   bit      receiver_steady = 1'b0;

   function automatic logic [15:0] tempo_for_interval(input logic [31:0] interval);
      logic [31:0] quotient;
      if (interval == 32'd0) begin
         return TEMPO_MAX;
      end
      quotient = 32'd240000 / interval;
      return (quotient > 32'd65535) ? TEMPO_MAX : quotient[15:0];
   endfunction

   function automatic rsp_type display_after_event(input req_type ev);
      rsp_type r;
      r = '0;
      case (ev.action)
         ACT_BEAT_ON: begin
            if (!shown_lit) begin
               r.display_write = 1'b1;
               case (next_digit)
                  2'd0: r.digit0_segments = DOT_PATTERN;
                  2'd1: r.digit1_segments = DOT_PATTERN;
                  2'd2: r.digit2_segments = DOT_PATTERN;
                  default: r.digit3_segments = DOT_PATTERN;
               endcase
               if (next_digit == 2'd0) begin
                  if (measure_start != 32'd0) begin
                     held_tempo = tempo_for_interval(ev.now_ms - measure_start);
                  end
                  measure_start = ev.now_ms;
               end
               next_digit = next_digit + 2'd1;
               shown_lit = 1'b1;
            end
         end
         ACT_BEAT_OFF: begin
            if (shown_lit) begin
               r.display_write = 1'b1;
               shown_lit = 1'b0;
            end
         end
         ACT_STOP: begin
            r.display_write = 1'b1;
            r.digit3_segments = DASH_PATTERN;
            shown_lit = 1'b0;
            next_digit = 2'd0;
         end
         default: begin
            next_digit = 2'd0;
            measure_start = 32'd0;
         end
      endcase
      r.tempo_bpm = held_tempo;
      return r;
   endfunction

   function automatic void compare_field(input string field, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         failures++;
      end
   endfunction

   task automatic check_display(input rsp_type got);
      rsp_type want;
      if (pending_displays.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual %0h", $time, got);
         failures++;
      end else begin
         want = pending_displays.pop_front();
         compare_field("display_write", 32'(want.display_write), 32'(got.display_write));
         compare_field("digit0_segments", 32'(want.digit0_segments),
                       32'(got.digit0_segments));
         compare_field("digit1_segments", 32'(want.digit1_segments),
                       32'(got.digit1_segments));
         compare_field("digit2_segments", 32'(want.digit2_segments),
                       32'(got.digit2_segments));
         compare_field("digit3_segments", 32'(want.digit3_segments),
                       32'(got.digit3_segments));
         compare_field("tempo_bpm", 32'(want.tempo_bpm), 32'(got.tempo_bpm));
      end
      results_checked++;
   endtask

   // The receiver takes one beat per loop, after a random or requested hold.
   initial begin : result_drain
      int wait_cycles;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (drain_hold_cycles > 0) begin
            wait_cycles = drain_hold_cycles;
            drain_hold_cycles = 0;
         end else begin
            wait_cycles = receiver_steady ? 0 : $urandom_range(0, 5);
         end
         if (wait_cycles > 0) begin
            rsp_pop <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty !== 1'b0);
         check_display(rsp_data);
      end
   end

   task automatic send_event(input action_type act, input logic [31:0] ms);
      req_type item;
      int      gap;
      item.action = act;
      item.now_ms = ms;
      gap = sender_steady ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      do begin
         @(posedge clock);
         if (req_full) input_stalls++;
      end while (req_full);
      pending_displays.push_back(display_after_event(item));
      events_sent++;
   endtask

   task automatic wait_all_results();
      req_push <= 1'b0;
      while (pending_displays.size() != 0) @(posedge clock);
   endtask

   task automatic test_display_events();
      send_event(ACT_BEAT_ON, 32'd100);
      send_event(ACT_BEAT_ON, 32'd150);
      send_event(ACT_BEAT_OFF, 32'd200);
      send_event(ACT_BEAT_OFF, 32'd210);
      send_event(ACT_BEAT_ON, 32'd300);
      send_event(ACT_BEAT_OFF, 32'd350);
      send_event(ACT_STOP, 32'd400);
      send_event(ACT_RESET, 32'd410);
   endtask

   // A stop rewinds to the first digit but keeps the measure start, so each
   // stop and beat-on pair measures one interval.
   task automatic test_tempo_corners();
      send_event(ACT_BEAT_ON, 32'd1000);
      send_event(ACT_STOP, 32'd1000);
      send_event(ACT_BEAT_ON, 32'd1000);
      send_event(ACT_STOP, 32'd1001);
      send_event(ACT_BEAT_ON, 32'd1003);
      send_event(ACT_STOP, 32'd1004);
      send_event(ACT_BEAT_ON, 32'd3);
      send_event(ACT_STOP, 32'd200);
      send_event(ACT_BEAT_ON, 32'd503);
      send_event(ACT_RESET, 32'hFFFF_FFFF);
      send_event(ACT_BEAT_ON, 32'd0);
      send_event(ACT_STOP, 32'd100);
      send_event(ACT_BEAT_ON, 32'd500);
      send_event(ACT_STOP, 32'd600);
      send_event(ACT_BEAT_ON, 32'hFFFF_FFFF);
   endtask

   task automatic test_backpressure();
      logic [31:0] ms;
      int          i;
      wait_all_results();
      sender_steady = 1'b1;
      drain_hold_cycles = 300;
      ms = 32'h0001_0000;
      for (i = 0; i < 12; i++) begin
         ms = ms + 32'd250;
         send_event(ACT_BEAT_ON, ms);
         ms = ms + 32'd5;
         send_event(ACT_BEAT_OFF, ms);
      end
      sender_steady = 1'b0;
      wait_all_results();
   endtask

   // Mostly well-formed beats at varied tempos, with stops, resets, missing
   // beat-offs and arbitrary events mixed in.
   task automatic test_random_traffic(input int count);
      logic [31:0] ms;
      logic [31:0] step;
      int          last;
      last = events_sent + count;
      ms = $urandom;
      while (events_sent < last) begin
         if ($urandom_range(0, 99) == 0) begin
            sender_steady = ($urandom_range(0, 3) == 0);
            receiver_steady = ($urandom_range(0, 3) == 0);
         end
         case ($urandom_range(0, 9))
            0: send_event(action_type'($urandom_range(0, 3)), $urandom);
            1: begin
               ms = ms + $urandom_range(0, 100);
               send_event($urandom_range(0, 1) ? ACT_STOP : ACT_RESET, ms);
            end
            default: begin
               case ($urandom_range(0, 9))
                  0: step = $urandom_range(0, 1);
                  1: step = $urandom;
                  default: step = $urandom_range(15, 1500);
               endcase
               ms = ms + step;
               send_event(ACT_BEAT_ON, ms);
               if ($urandom_range(0, 15) != 0) begin
                  ms = ms + $urandom_range(0, 20);
                  send_event(ACT_BEAT_OFF, ms);
               end
            end
         endcase
      end
      sender_steady = 1'b0;
      receiver_steady = 1'b0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_display_events();
      test_tempo_corners();
      test_backpressure();
      test_random_traffic(1800);
      wait_all_results();
      repeat (50) @(posedge clock);
      if (pending_displays.size() != 0) failures++;
      $display("Covered %0d events (display, tempo corners, back-pressure, random beats),",
               events_sent);
      $display("checked %0d results, saw %0d stalled input cycles, %0d mismatches.",
               results_checked, input_stalls, failures);
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> files.f
hdl/btm_pkg.sv
hdl/btm_cmd_fifo.sv
hdl/btm_front.sv
hdl/btm_back.sv
hdl/beat_indicator_tempo_meter_core.sv
dv/tb_top.sv
